### design/itds_pkg.sv
package itds_pkg;

   localparam int DIVIDER_STEPS = 256;
   localparam int CYCLE_LIMIT   = 512;

   localparam int CLK_W   = 32;
   localparam int FREQ_W  = 24;
   localparam int FILT_W  = 3;
   localparam int DIV_W   = 8;
   localparam int CYC_W   = 9;
   localparam int REQ_W   = 56;
   localparam int RSP_W   = 112;

   // fixed part of the base count: clock/freq - BASE_OFFSET - 2*filter
   localparam int BASE_OFFSET = 8;
   // smallest quotient that gives a usable period (period >= 2)
   localparam int QUO_MIN     = 4;

   typedef struct packed {
      logic             done;
      logic [CLK_W-1:0] quotient;
   } div_stat_type;

endpackage

### design/itds_div.sv
module itds_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [itds_pkg::CLK_W-1:0]    dividend,
   input  logic [itds_pkg::FREQ_W-1:0]   divisor,
   output itds_pkg::div_stat_type        stat
);

   localparam int CNT_W = $clog2(itds_pkg::CLK_W);

   logic                          run_ff, run_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [itds_pkg::CLK_W-1:0]    quo_ff, quo_in;
   logic [itds_pkg::FREQ_W-1:0]   rem_ff, rem_in;
   logic [itds_pkg::FREQ_W-1:0]   dvs_ff, dvs_in;
   logic                          done_ff, done_in;
   logic [itds_pkg::FREQ_W:0]     trial;
   logic [itds_pkg::FREQ_W:0]     diff;

   // restoring step: one quotient bit per cycle, dividend shifts out of quo_ff msb
   assign trial = {rem_ff, quo_ff[itds_pkg::CLK_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         if (diff[itds_pkg::FREQ_W]) begin
            rem_in = trial[itds_pkg::FREQ_W-1:0];
            quo_in = {quo_ff[itds_pkg::CLK_W-2:0], 1'b0};
         end else begin
            rem_in = diff[itds_pkg::FREQ_W-1:0];
            quo_in = {quo_ff[itds_pkg::CLK_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(itds_pkg::CLK_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

### design/i2c_timing_divider_search.sv
// channel | direction | tdata / tuser
// req     | in        | tdata[55:0]: clock_in_hz, bus_freq_hz
// rsp     | out       | tdata[111:0]: divider, cycles, timing words; tuser: status
// csr     | in        | csr_wdata[2:0]: filter_cycles
//
// One request at a time. A shared bit-serial divider first forms clock/freq, then
// tries dividers 1..256 in turn. Zero frequency skips both divisions, and a base
// count below 4 ends the request without trying any divider.
// A finished result waits in an output register; the next request is taken meanwhile.
// reset is synchronous; it clears the filter register and all control state.
module i2c_timing_divider_search (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wen,
   input  logic [2:0]    csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [55:0]   req_tdata,   // clock_in_hz[31:0], bus_freq_hz[55:32]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,   // clock_divider[7:0], scl_cycles[16:8],
                                      // timing_word_one[48:17], timing_word_two[80:49],
                                      // timing_word_three[104:81], data_hold_word[111:105]
   output logic          rsp_tuser    // status
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV1 = 3'd1;
   localparam logic [2:0] ST_BASE = 3'd2;
   localparam logic [2:0] ST_DIV2 = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam int CLK_W = itds_pkg::CLK_W;
   localparam int CYC_W = itds_pkg::CYC_W;
   localparam int DIV_W = itds_pkg::DIV_W;

   logic [2:0]                      state_ff, state_in;
   logic [itds_pkg::FILT_W-1:0]     filt_ff, filt_in;
   logic [CLK_W-1:0]                base_ff, base_in;
   logic [CYC_W-1:0]                cand_ff, cand_in;
   logic                            res_st_ff, res_st_in;
   logic [DIV_W-1:0]                res_dv_ff, res_dv_in;
   logic [CYC_W-1:0]                res_cy_ff, res_cy_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_st_ff, rsp_st_in;
   logic [DIV_W-1:0]                rsp_dv_ff, rsp_dv_in;
   logic [CYC_W-1:0]                rsp_cy_ff, rsp_cy_in;

   logic                            div_start;
   logic [CLK_W-1:0]                div_dividend;
   logic [itds_pkg::FREQ_W-1:0]     div_divisor;
   itds_pkg::div_stat_type          div_stat;

   logic [CLK_W-1:0]                req_clk;
   logic [itds_pkg::FREQ_W-1:0]     req_freq;
   logic                            req_xfer;
   logic [5:0]                      base_sub;
   logic                            quo_ok;
   logic [CYC_W-2:0]                half;
   logic [CYC_W-3:0]                quarter;

   assign req_clk  = req_tdata[CLK_W-1:0];
   assign req_freq = req_tdata[55:CLK_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer = req_tvalid && req_tready;

   assign base_sub = 6'(itds_pkg::BASE_OFFSET) + {2'b00, filt_ff, 1'b0};
   assign quo_ok   = (div_stat.quotient >= CLK_W'(itds_pkg::QUO_MIN)) &&
                     (div_stat.quotient <  CLK_W'(itds_pkg::CYCLE_LIMIT + 2));

   itds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      filt_in      = filt_ff;
      base_in      = base_ff;
      cand_in      = cand_ff;
      res_st_in    = res_st_ff;
      res_dv_in    = res_dv_ff;
      res_cy_in    = res_cy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_dv_in    = rsp_dv_ff;
      rsp_cy_in    = rsp_cy_ff;
      div_start    = 1'b0;
      div_dividend = base_ff;
      div_divisor  = {{(itds_pkg::FREQ_W - CYC_W){1'b0}}, cand_ff};

      if (csr_wen) begin
         filt_in = csr_wdata;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            div_dividend = req_clk;
            div_divisor  = req_freq;
            if (req_xfer) begin
               res_st_in = 1'b1;
               res_dv_in = '0;
               res_cy_in = '0;
               if (req_freq == '0) begin
                  state_in = ST_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV1;
               end
            end
         end
         ST_DIV1: begin
            if (div_stat.done) begin
               // base below QUO_MIN (or negative) can never give a valid period
               if (div_stat.quotient < CLK_W'(base_sub) + CLK_W'(itds_pkg::QUO_MIN)) begin
                  state_in = ST_DONE;
               end else begin
                  base_in  = div_stat.quotient - CLK_W'(base_sub);
                  cand_in  = CYC_W'(1);
                  state_in = ST_BASE;
               end
            end
         end
         ST_BASE: begin
            div_start = 1'b1;
            state_in  = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_stat.done) begin
               if (quo_ok) begin
                  res_st_in = 1'b0;
                  res_dv_in = DIV_W'(cand_ff - 1'b1);
                  res_cy_in = CYC_W'(div_stat.quotient - CLK_W'(2));
                  state_in  = ST_DONE;
               end else if (cand_ff == CYC_W'(itds_pkg::DIVIDER_STEPS)) begin
                  state_in = ST_DONE;
               end else begin
                  cand_in     = cand_ff + 1'b1;
                  div_divisor = {{(itds_pkg::FREQ_W - CYC_W){1'b0}}, cand_ff + 1'b1};
                  div_start   = 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_dv_in    = res_dv_ff;
               rsp_cy_in    = res_cy_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filt_ff      <= filt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff   <= base_in;
      cand_ff   <= cand_in;
      res_st_ff <= res_st_in;
      res_dv_ff <= res_dv_in;
      res_cy_ff <= res_cy_in;
      rsp_st_ff <= rsp_st_in;
      rsp_dv_ff <= rsp_dv_in;
      rsp_cy_ff <= rsp_cy_in;
   end

   // failure leaves divider and cycles at zero, so every word packs to zero
   assign half    = rsp_cy_ff[CYC_W-1:1];
   assign quarter = rsp_cy_ff[CYC_W-1:2];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = {
      quarter,                                   // data_hold_word
      rsp_dv_ff, 7'b0, rsp_cy_ff,                // timing_word_three
      1'b0, quarter, 8'b0, half, half,           // timing_word_two
      half, half, half, 8'b0,                    // timing_word_one
      rsp_cy_ff,                                 // scl_cycles
      rsp_dv_ff                                  // clock_divider
   };

endmodule

### dv/tb_i2c_timing_divider_search.sv
`timescale 1ns / 100ps

module tb_i2c_timing_divider_search;
   import itds_pkg::*;

   localparam int IDLE_LIMIT = 40000;

   typedef enum logic {
      TIMING_FOUND = 1'b0,
      TIMING_FAIL  = 1'b1
   } timing_status_e;

   // same layout as rsp_tdata, lowest field last
   typedef struct packed {
      logic [6:0]       data_hold;
      logic [23:0]      word_three;
      logic [31:0]      word_two;
      logic [31:0]      word_one;
      logic [CYC_W-1:0] cycles;
      logic [DIV_W-1:0] divider;
   } timing_words_t;

   typedef struct packed {
      timing_status_e status;
      timing_words_t  words;
   } timing_result_t;

   class timing_scoreboard;
      timing_result_t pending_timing[$];
      int unsigned    errors = 0;

      function timing_result_t compute_timing(logic [CLK_W-1:0] clk_hz,
                                              logic [FREQ_W-1:0] freq_hz,
                                              logic [FILT_W-1:0] filt);
         timing_result_t r;
         longint         quo;
         longint         filt_l;
         longint         base;
         longint         period;
         logic [CYC_W-1:0] cyc;
         logic [7:0]     half;
         logic [7:0]     quarter;
         bit             found;
         r = '0;
         r.status = TIMING_FAIL;
         found = 1'b0;
         if (freq_hz != '0) begin
            quo    = clk_hz / freq_hz;
            filt_l = filt;
            base   = quo - BASE_OFFSET - 2 * filt_l;
            // signed division truncates toward zero, so a negative base never fits
            for (int d = 0; d < DIVIDER_STEPS && !found; d++) begin
               period = base / (d + 1) - 2;
               if (period >= 2 && period < CYCLE_LIMIT) begin
                  found   = 1'b1;
                  cyc     = period[CYC_W-1:0];
                  half    = cyc[8:1];
                  quarter = {1'b0, cyc[8:2]};
                  r.status           = TIMING_FOUND;
                  r.words.divider    = d[DIV_W-1:0];
                  r.words.cycles     = cyc;
                  r.words.word_one   = {half, half, half, 8'h00};
                  r.words.word_two   = {quarter, 8'h00, half, half};
                  r.words.word_three = {d[7:0], 7'd0, cyc};
                  r.words.data_hold  = quarter[6:0];
               end
            end
         end
         return r;
      endfunction

      function void note_request(logic [CLK_W-1:0] clk_hz, logic [FREQ_W-1:0] freq_hz,
                                 logic [FILT_W-1:0] filt);
         pending_timing.push_back(compute_timing(clk_hz, freq_hz, filt));
      endfunction

      function void compare_field(string label, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
         end
      endfunction

      function void check_result(logic [RSP_W-1:0] tdata, logic tuser);
         timing_words_t  got;
         timing_result_t want;
         got = tdata;
         if (pending_timing.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %h / %b",
                     $time, tdata, tuser);
         end else begin
            want = pending_timing.pop_front();
            compare_field("status", 32'(want.status), 32'(tuser));
            compare_field("clock_divider", 32'(want.words.divider), 32'(got.divider));
            compare_field("scl_cycles", 32'(want.words.cycles), 32'(got.cycles));
            compare_field("timing_word_one", want.words.word_one, got.word_one);
            compare_field("timing_word_two", want.words.word_two, got.word_two);
            compare_field("timing_word_three", 32'(want.words.word_three),
                          32'(got.word_three));
            compare_field("data_hold_word", 32'(want.words.data_hold), 32'(got.data_hold));
         end
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               csr_wen    = 1'b0;
   logic [FILT_W-1:0]  csr_wdata  = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tuser;

   timing_scoreboard   sb;
   logic [FILT_W-1:0]  filter_setting = '0;
   int unsigned        burst_left     = 0;
   int unsigned        stall_mode     = 0;
   int unsigned        stall_hold     = 0;
   int unsigned        idle_cycles    = 0;

   i2c_timing_divider_search i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver: switches between always ready, coin flip and mostly stalled
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
         if (stall_hold == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_hold = $urandom_range(16, 200);
         end else begin
            stall_hold--;
         end
         case (stall_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_tready <= ($urandom_range(0, 7) == 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("i2c_timing_divider_search regression: fail");
         $finish;
      end
   end

   task automatic send_request(input logic [CLK_W-1:0] clk_hz,
                               input logic [FREQ_W-1:0] freq_hz);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {freq_hz, clk_hz};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(clk_hz, freq_hz, filter_setting);
      burst_left--;
   endtask

   // clock/freq lands exactly on ratio, with random content below it
   task automatic send_at_ratio(input longint unsigned ratio);
      longint unsigned fmax;
      longint unsigned fq;
      longint unsigned ck;
      fmax = 64'hFFFF_FFFF / (ratio + 1);
      if (fmax > 64'hFF_FFFF)
         fmax = 64'hFF_FFFF;
      fq = 64'($urandom_range(1, 32'(fmax)));
      ck = ratio * fq + 64'($urandom_range(0, 32'(fq - 1)));
      send_request(ck[31:0], fq[23:0]);
   endtask

   task automatic send_random_request();
      int unsigned     mode;
      int unsigned     d;
      int unsigned     p;
      longint unsigned ratio;
      longint unsigned fq;
      longint unsigned ck;
      longint unsigned filt;
      filt = filter_setting;
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
         // aim at a given divider and period; mostly small dividers to keep it quick
         d = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
         p = $urandom_range(2, 511);
         ratio = longint'(d + 1) * (p + 2) + $urandom_range(0, d) + BASE_OFFSET + 2 * filt;
         send_at_ratio(ratio);
      end else if (mode <= 7) begin
         send_request($urandom, 24'($urandom_range(0, 24'hFF_FFFF)));
      end else if (mode == 8) begin
         send_request($urandom, '0);
      end else begin
         // base count at or below zero
         fq = 64'($urandom_range(1, 24'hFF_FFFF));
         ck = fq * $urandom_range(0, 32'(BASE_OFFSET + 2 * filt))
              + $urandom_range(0, 32'(fq - 1));
         send_request(ck[31:0], fq[23:0]);
      end
   endtask

   task automatic send_edge_requests();
      longint unsigned filt2;
      filt2 = 2 * filter_setting;
      send_at_ratio(12 + filt2);      // smallest usable period
      send_at_ratio(11 + filt2);      // one below it
      send_at_ratio(521 + filt2);     // largest period at divider zero
      send_at_ratio(522 + filt2);     // spills to divider one
      send_at_ratio(131591 + filt2);  // last divider, largest period
      send_at_ratio(131592 + filt2);  // just past every divider
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending_timing.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_filter(input logic [FILT_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      filter_setting = value;
      csr_wen <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count);
      repeat (count) send_random_request();
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(32'hFFFF_FFFF, 24'h00_0000);
      send_request(32'h0000_0000, 24'h00_0000);
      send_request(32'hFFFF_FFFF, 24'hFF_FFFF);
      send_request(32'h0000_0000, 24'h00_0001);
      send_request(32'h8000_0000, 24'h80_0000);
      send_request(32'h0000_03E8, 24'hFF_FFFF);
      send_request(32'hFFFF_FFFF, 24'h00_0001);
      send_edge_requests();
      run_random(20);
      drain();

      write_filter(3'd7);
      send_edge_requests();
      run_random(25);
      drain();

      write_filter(3'd3);
      run_random(20);
      drain();

      write_filter(3'($urandom_range(1, 6)));
      run_random(20);
      drain();

      write_filter(3'd0);
      run_random(15);
      drain();

      repeat (50) @(posedge clock);
      if (sb.pending_timing.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d results never arrived", $time, sb.pending_timing.size());
      end
      if (sb.errors == 0)
         $display("i2c_timing_divider_search regression: pass");
      else
         $display("i2c_timing_divider_search regression: fail");
      $finish;
   end

endmodule
